### design/sgdm_pkg.sv
// Shared types, register indexes and fixed-point helpers for the SGD momentum update unit.
package sgdm_pkg;

  localparam int unsigned CfgW  = 16;
  localparam int unsigned IdxW  = 12;
  localparam int unsigned DataW = 32;

  // Configuration register indexes.
  localparam logic [1:0] CFG_STEP_RATE = 2'd0;
  localparam logic [1:0] CFG_MOMENTUM  = 2'd1;
  localparam logic [1:0] CFG_DECAY     = 2'd2;

  // Result buffer depth; it also bounds the words in flight.
  localparam int unsigned FifoDepth = 8;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic [CfgW-1:0] step_rate;
    logic [CfgW-1:0] momentum_factor;
    logic [CfgW-1:0] decay_factor;
  } cfg_t;

  typedef struct packed {
    logic [DataW-1:0] weight;
    logic [IdxW-1:0]  index;
    logic             sat;
  } result_t;

  // Q0.16 factor times Q16.16 value, rounded half up. The arithmetic shift
  // gives the floor, which matches the rounding for both signs.
  function automatic logic signed [DataW-1:0] frac_mul(input logic [CfgW-1:0] f,
                                                       input logic signed [DataW-1:0] x);
    logic signed [48:0] fe;
    logic signed [48:0] xe;
    logic signed [48:0] p;
    fe = {33'd0, f};
    xe = {{17{x[31]}}, x};
    p  = fe * xe + 49'sd32768;
    return p[47:16];
  endfunction

  function automatic logic clip_ovf(input logic [DataW:0] s);
    return s[DataW] ^ s[DataW-1];
  endfunction

  function automatic logic [DataW-1:0] clip_val(input logic [DataW:0] s);
    logic [DataW-1:0] r;
    r = s[DataW-1:0];
    if (s[DataW] ^ s[DataW-1]) begin
      r = s[DataW] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    return r;
  endfunction

endpackage

### design/sgdm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module sgdm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/sgdm_datapath.sv
// Three-stage update pipeline: decay, velocity read-modify-write with forwarding, weight step.
module sgdm_datapath #(
  parameter int unsigned ELEMENT_COUNT = 4096,
  localparam int unsigned AW = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sgdm_pkg::cfg_t         cfg_i,
  input  logic                   in_fire_i,
  input  logic [11:0]            element_index_i,
  input  logic signed [31:0]     weight_in_i,
  input  logic signed [31:0]     gradient_i,
  input  logic                   update_enable_i,
  output logic [AW-1:0]          rd_addr_o,
  input  logic [31:0]            rd_data_i,
  output logic                   wr_en_o,
  output logic [AW-1:0]          wr_addr_o,
  output logic [31:0]            wr_data_o,
  output logic                   res_valid_o,
  output sgdm_pkg::result_t      res_o,
  output logic [1:0]             busy_cnt_o
);
  import sgdm_pkg::*;

  // Stage control.
  logic v1_q, v2_q, v3_q, wr3_q;

  // Stage payload.
  logic [IdxW-1:0]         idx1_q, idx2_q, idx3_q;
  logic signed [DataW-1:0] w1_q, w2_q, w3_q;
  logic signed [DataW-1:0] g1_q;
  logic                    en1_q, en2_q, en3_q;
  logic signed [DataW-1:0] gp2_q;
  logic                    sat2_q, sat3_q;
  logic signed [DataW-1:0] vold2_q;
  logic                    inr2_q;
  logic signed [DataW-1:0] src3_q;

  // Stage 1 logic.
  logic signed [DataW-1:0] dp;
  logic [DataW:0]          gsum;
  logic                    decay_on;
  logic signed [DataW-1:0] gp_d;
  logic                    sat1_d;
  logic                    inr1;
  logic signed [DataW-1:0] vold_d;
  logic [31:0]             idx1_ext;

  // Stage 2 logic.
  logic signed [DataW-1:0] mp;
  logic [DataW:0]          vsum;
  logic signed [DataW-1:0] vnew;
  logic                    mom_on;
  logic                    wr2;
  logic signed [DataW-1:0] src_d;
  logic                    sat2_d;
  logic [31:0]             idx2_ext;
  logic [31:0]             idx_in_ext;

  // Stage 3 logic.
  logic signed [DataW-1:0] step;
  logic [DataW:0]          wdiff;

  assign idx_in_ext = 32'(element_index_i);
  assign rd_addr_o  = idx_in_ext[AW-1:0];

  always_comb begin
    decay_on = |cfg_i.decay_factor;
    dp       = frac_mul(cfg_i.decay_factor, w1_q);
    gsum     = {g1_q[31], g1_q} + {dp[31], dp};
    gp_d     = decay_on ? clip_val(gsum) : g1_q;
    sat1_d   = decay_on & clip_ovf(gsum);
    idx1_ext = 32'(idx1_q);
    inr1     = idx1_ext < ELEMENT_COUNT;
    // The item one stage ahead writes at this edge and the one two ahead wrote
    // while this item's read was in flight, so both bypass the memory word.
    if (!inr1) begin
      vold_d = '0;
    end else if (wr2 && (idx2_q == idx1_q)) begin
      vold_d = vnew;
    end else if (wr3_q && (idx3_q == idx1_q)) begin
      vold_d = src3_q;
    end else begin
      vold_d = rd_data_i;
    end
  end

  always_comb begin
    mom_on   = |cfg_i.momentum_factor;
    mp       = frac_mul(cfg_i.momentum_factor, vold2_q);
    vsum     = {mp[31], mp} + {gp2_q[31], gp2_q};
    vnew     = clip_val(vsum);
    wr2      = v2_q & en2_q & mom_on & inr2_q;
    src_d    = mom_on ? vnew : gp2_q;
    sat2_d   = sat2_q | (mom_on & clip_ovf(vsum));
    idx2_ext = 32'(idx2_q);
  end

  assign wr_en_o   = wr2;
  assign wr_addr_o = idx2_ext[AW-1:0];
  assign wr_data_o = vnew;

  always_comb begin
    step         = frac_mul(cfg_i.step_rate, src3_q);
    wdiff        = {w3_q[31], w3_q} - {step[31], step};
    res_o.index  = idx3_q;
    res_o.weight = en3_q ? clip_val(wdiff) : w3_q;
    res_o.sat    = en3_q & (sat3_q | clip_ovf(wdiff));
  end

  assign res_valid_o = v3_q;
  assign busy_cnt_o  = {1'b0, v1_q} + {1'b0, v2_q} + {1'b0, v3_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      wr3_q <= 1'b0;
    end else begin
      v1_q  <= in_fire_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      wr3_q <= wr2;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q  <= element_index_i;
    w1_q    <= weight_in_i;
    g1_q    <= gradient_i;
    en1_q   <= update_enable_i;
    idx2_q  <= idx1_q;
    w2_q    <= w1_q;
    en2_q   <= en1_q;
    gp2_q   <= gp_d;
    sat2_q  <= sat1_d;
    vold2_q <= vold_d;
    inr2_q  <= inr1;
    idx3_q  <= idx2_q;
    w3_q    <= w2_q;
    en3_q   <= en2_q;
    src3_q  <= src_d;
    sat3_q  <= sat2_d;
  end

endmodule

### design/sgdm_out_fifo.sv
// Result buffer between the pipeline and the output channel.
module sgdm_out_fifo (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_i,
  input  sgdm_pkg::result_t                    push_data_i,
  input  logic                                 pop_i,
  output logic                                 valid_o,
  output sgdm_pkg::result_t                    data_o,
  output logic [$clog2(sgdm_pkg::FifoDepth+1)-1:0] count_o
);
  import sgdm_pkg::*;

  result_t             buf_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q + FifoPtrW'(push_i);
    rd_ptr_d = rd_ptr_q + FifoPtrW'(pop_i);
    cnt_d    = cnt_q + FifoCntW'(push_i) - FifoCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = cnt_q != '0;
  assign data_o  = buf_q[rd_ptr_q];
  assign count_o = cnt_q;

endmodule

### design/sgd_momentum_update_unit.sv
// Top level of the SGD momentum update unit: registers, velocity memory, clear sweep, flow control.
//
// Input channel: one word per parameter element (index, weight, gradient,
// enable), taken at a clock edge with in_valid_i high and in_stall_o low.
// Output channel: one word per input word, in order (new weight, echoed
// index, saturation flag), taken when out_valid_o is high and out_stall_i low.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i
// (0 learning rate, 1 momentum, 2 decay); other indexes are ignored.
// Each accepted word passes the decay, velocity and weight-step stages and the result buffer; one
// word per cycle is sustained while in_stall_o stays low, set by the velocity read-modify-write,
// which bypasses in-flight updates so a repeated index may follow in the next cycle.
// After reset the velocity memory is swept to zero, one entry per cycle, over
// all ELEMENT_COUNT entries; in_stall_o stays high during the sweep.
// An 8-entry result buffer decouples the pipeline from the receiver: while it
// stalls, up to 8 words in total may be in flight or buffered, then
// in_stall_o rises until results drain.
module sgd_momentum_update_unit #(
  parameter int unsigned ELEMENT_COUNT = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [11:0]        element_index_i,
  input  logic signed [31:0] weight_in_i,
  input  logic signed [31:0] gradient_i,
  input  logic               update_enable_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] weight_out_o,
  output logic [11:0]        index_out_o,
  output logic               saturated_o
);
  import sgdm_pkg::*;

  localparam int unsigned AW = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;
  localparam logic [AW-1:0] LastAddr = AW'(ELEMENT_COUNT - 1);

  cfg_t                cfg_q, cfg_d;
  logic                clr_q, clr_d;
  logic [AW-1:0]       clr_cnt_q, clr_cnt_d;

  logic                in_fire;
  logic                pop;
  logic [AW-1:0]       rd_addr;
  logic [31:0]         rd_data;
  logic                dp_wr_en;
  logic [AW-1:0]       dp_wr_addr;
  logic [31:0]         dp_wr_data;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [31:0]         ram_wdata;
  logic                res_valid;
  result_t             res;
  result_t             out_word;
  logic [1:0]          busy_cnt;
  logic [FifoCntW-1:0] fifo_cnt;
  logic [FifoCntW:0]   inflight;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_STEP_RATE: cfg_d.step_rate       = cfg_data_i;
        CFG_MOMENTUM:  cfg_d.momentum_factor = cfg_data_i;
        CFG_DECAY:     cfg_d.decay_factor    = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      if (clr_cnt_q == LastAddr) begin
        clr_d = 1'b0;
      end else begin
        clr_cnt_d = clr_cnt_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_rate       <= 16'd655;
      cfg_q.momentum_factor <= 16'd0;
      cfg_q.decay_factor    <= 16'd0;
      clr_q                 <= 1'b1;
      clr_cnt_q             <= '0;
    end else begin
      cfg_q     <= cfg_d;
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // Credit check: every accepted word has a buffer slot waiting for it.
  assign inflight   = (FifoCntW+1)'(busy_cnt) + (FifoCntW+1)'(fifo_cnt);
  assign in_stall_o = clr_q | (inflight >= (FifoCntW+1)'(FifoDepth));
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign pop        = out_valid_o & ~out_stall_i;

  assign ram_we    = clr_q | dp_wr_en;
  assign ram_waddr = clr_q ? clr_cnt_q : dp_wr_addr;
  assign ram_wdata = clr_q ? 32'd0 : dp_wr_data;

  sgdm_ram #(
    .WIDTH (32),
    .DEPTH (ELEMENT_COUNT)
  ) u_vel_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  sgdm_datapath #(
    .ELEMENT_COUNT (ELEMENT_COUNT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_fire_i       (in_fire),
    .element_index_i (element_index_i),
    .weight_in_i     (weight_in_i),
    .gradient_i      (gradient_i),
    .update_enable_i (update_enable_i),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data),
    .wr_en_o         (dp_wr_en),
    .wr_addr_o       (dp_wr_addr),
    .wr_data_o       (dp_wr_data),
    .res_valid_o     (res_valid),
    .res_o           (res),
    .busy_cnt_o      (busy_cnt)
  );

  sgdm_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .pop_i       (pop),
    .valid_o     (out_valid_o),
    .data_o      (out_word),
    .count_o     (fifo_cnt)
  );

  assign weight_out_o = out_word.weight;
  assign index_out_o  = out_word.index;
  assign saturated_o  = out_word.sat;

endmodule

### design/sgdm_checker.sv
// Port-level checks for the SGD momentum update unit and the bind that attaches them.
module sgdm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] weight_out_o,
  input logic [11:0] index_out_o,
  input logic        saturated_o
);

  localparam logic [3:0] MaxOutstanding = 4'd8;

  logic       acc;
  logic       pop;
  logic [3:0] outst_q, outst_d;

  assign acc     = in_valid_i & ~in_stall_o;
  assign pop     = out_valid_o & ~out_stall_i;
  assign outst_d = outst_q + 4'(acc) - 4'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else begin
      outst_q <= outst_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(weight_out_o) &&
      $stable(index_out_o) && $stable(saturated_o))
    else $error("stalled output word changed");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> outst_q != 4'd0)
    else $error("output word without an accepted input word");

  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outst_q <= MaxOutstanding)
    else $error("more words outstanding than the result buffer holds");

  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_o)
    else $error("input accepted before the velocity memory was cleared");

endmodule

bind sgd_momentum_update_unit sgdm_checker u_sgdm_checker (.*);
